### rtl/pctd_pkg.sv
// Shared types and constants for the prefix code tree decoder.
`timescale 1ns / 1ps
package pctd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int IDX_W        = $clog2(NODE_COUNT);
  localparam int USED_W       = $clog2(NODE_COUNT + 1);
  localparam int MAX_CODE_LEN = 32;
  localparam int WORD_BITS    = 32;
  localparam int FIELD_BITS   = 32;
  localparam int CNT_W        = 6;
  localparam int SYM_W        = 8;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0] kid1;
    logic [IDX_W-1:0] kid0;
    logic             mark;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             sym_v;
    logic             found;
    logic [2:0]       status;
  } rslt_t;

  typedef struct packed {
    logic  emit;
    logic  flush;
    rslt_t res;
  } out_ctl_t;

  typedef struct packed {
    logic pend_v;
    logic slot;
  } out_sts_t;

endpackage

### rtl/pctd_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pctd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/pctd_out.sv
// Result holding stage and output register; marks the last result of a request.
`timescale 1ns / 1ps
module pctd_out (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pctd_pkg::out_ctl_t      ctl,
  output pctd_pkg::out_sts_t      sts,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_symbol_out,
  output logic                    out_symbol_valid,
  output logic                    out_found,
  output logic [2:0]              out_status,
  output logic                    out_last
);

  logic            pend_v_r;
  pctd_pkg::rslt_t pend_r;
  logic            out_v_r;
  pctd_pkg::rslt_t out_r;
  logic            out_last_r;
  logic            slot;
  logic            push;

  assign slot = !out_v_r || !out_stall;
  assign push = pend_v_r && (ctl.emit || ctl.flush);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (push) begin
        out_v_r <= 1'b1;
      end else if (slot) begin
        out_v_r <= 1'b0;
      end
      if (ctl.emit) begin
        pend_v_r <= 1'b1;
      end else if (ctl.flush) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r      <= pend_r;
      out_last_r <= ctl.flush;
    end
    if (ctl.emit) begin
      pend_r <= ctl.res;
    end
  end

  assign sts.pend_v       = pend_v_r;
  assign sts.slot         = slot;
  assign out_valid        = out_v_r;
  assign out_symbol_out   = out_r.sym;
  assign out_symbol_valid = out_r.sym_v;
  assign out_found        = out_r.found;
  assign out_status       = out_r.status;
  assign out_last         = out_last_r;

endmodule

### rtl/prefix_code_tree_decoder.sv
// Top level: code tree walker over the node RAM, add, lookup and decode.
// Each walk step uses one code bit; add takes an extra step per node allocated and
// decode holds while the output cannot take a result. One request at a time: the next
// is taken once the last result of the one before has reached the output register.
// Reset: root node cleared, one node in use, decode cursor at root; the node
// RAM needs no clearing pass, nodes are written as they are allocated.
`timescale 1ns / 1ps
module prefix_code_tree_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_code_bits,
  input  logic [5:0]  in_code_length,
  input  logic [7:0]  in_symbol_in,
  input  logic [31:0] in_data_word,
  input  logic [5:0]  in_bit_count,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_symbol_out,
  output logic        out_symbol_valid,
  output logic        out_found,
  output logic [2:0]  out_status,
  output logic        out_last
);

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_ALLOC, S_END, S_FLUSH} state_t;

  localparam int IW = pctd_pkg::IDX_W;
  localparam int UW = pctd_pkg::USED_W;
  localparam int CW = pctd_pkg::CNT_W;
  localparam int FW = pctd_pkg::FIELD_BITS;

  state_t                state_r, state_nxt;
  logic [1:0]            act_r, act_nxt;
  logic [FW-1:0]         sh_r, sh_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [7:0]            sym_in_r, sym_in_nxt;
  logic                  fin_r, fin_nxt;
  logic [IW-1:0]         cur_r, cur_nxt;
  logic                  use_rd_r, use_rd_nxt;
  logic                  chk_r, chk_nxt;
  pctd_pkg::node_t       root_r, root_nxt;
  logic [UW-1:0]         used_r, used_nxt;
  logic [IW-1:0]         cursor_r, cursor_nxt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  pctd_pkg::node_t       ram_wdata;
  logic                  ram_re;
  logic [IW-1:0]         ram_raddr;
  pctd_pkg::node_t       ram_rdata;

  pctd_pkg::out_ctl_t    octl;
  pctd_pkg::out_sts_t    osts;

  pctd_pkg::node_t       node_v;
  pctd_pkg::node_t       node_upd;
  logic                  bit_c;
  logic [IW-1:0]         child;
  logic                  can_emit;
  logic                  full;
  logic [CW-1:0]         len_c;
  logic [CW-1:0]         cnt_c;

  pctd_ram #(
    .WIDTH($bits(pctd_pkg::node_t)),
    .DEPTH(pctd_pkg::NODE_COUNT)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  pctd_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (octl),
    .sts             (osts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol_out  (out_symbol_out),
    .out_symbol_valid(out_symbol_valid),
    .out_found       (out_found),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  assign in_stall = (state_r != S_IDLE);
  assign can_emit = !osts.pend_v || osts.slot;
  assign full     = (used_r == UW'(pctd_pkg::NODE_COUNT));
  assign bit_c    = sh_r[FW-1];

  always_comb begin
    if (cur_r == '0) begin
      node_v = root_r;
    end else if (use_rd_r) begin
      node_v = ram_rdata;
    end else begin
      node_v = '0;
    end
  end

  assign child = bit_c ? node_v.kid1 : node_v.kid0;

  assign len_c = (in_code_length > CW'(pctd_pkg::MAX_CODE_LEN)) ?
                 CW'(pctd_pkg::MAX_CODE_LEN) : in_code_length;
  assign cnt_c = (in_bit_count > CW'(pctd_pkg::WORD_BITS)) ?
                 CW'(pctd_pkg::WORD_BITS) : in_bit_count;

  always_comb begin
    state_nxt  = state_r;
    act_nxt    = act_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    sym_in_nxt = sym_in_r;
    fin_nxt    = fin_r;
    cur_nxt    = cur_r;
    use_rd_nxt = use_rd_r;
    chk_nxt    = chk_r;
    root_nxt   = root_r;
    used_nxt   = used_r;
    cursor_nxt = cursor_r;
    ram_we     = 1'b0;
    ram_waddr  = cur_r;
    ram_wdata  = node_v;
    ram_re     = 1'b0;
    ram_raddr  = child;
    octl       = '0;
    node_upd   = node_v;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          sym_in_nxt = in_symbol_in;
          fin_nxt    = in_final_word;
          chk_nxt    = 1'b0;
          if (in_action == pctd_pkg::ACT_DECODE) begin
            sh_nxt     = in_data_word;
            cnt_nxt    = cnt_c;
            cur_nxt    = cursor_r;
            use_rd_nxt = (cursor_r != '0);
            ram_re     = 1'b1;
            ram_raddr  = cursor_r;
            state_nxt  = S_WALK;
          end else if (in_action == pctd_pkg::ACT_ADD ||
                       in_action == pctd_pkg::ACT_LOOKUP) begin
            sh_nxt     = in_code_bits << (CW'(FW) - len_c);
            cnt_nxt    = len_c;
            cur_nxt    = '0;
            use_rd_nxt = 1'b0;
            state_nxt  = S_WALK;
          end
        end
      end

      S_WALK: begin
        unique case (act_r)
          pctd_pkg::ACT_ADD: begin
            if (cnt_r != '0) begin
              if (child != '0) begin
                cur_nxt    = child;
                ram_re     = 1'b1;
                use_rd_nxt = 1'b1;
                cnt_nxt    = cnt_r - CW'(1);
                sh_nxt     = sh_r << 1;
              end else if (full) begin
                octl.emit       = 1'b1;
                octl.res.status = pctd_pkg::ST_FULL;
                state_nxt       = S_FLUSH;
              end else begin
                if (bit_c) begin
                  node_upd.kid1 = used_r[IW-1:0];
                end else begin
                  node_upd.kid0 = used_r[IW-1:0];
                end
                if (cur_r == '0) begin
                  root_nxt = node_upd;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = node_upd;
                end
                state_nxt = S_ALLOC;
              end
            end else begin
              node_upd.mark = 1'b1;
              node_upd.sym  = sym_in_r;
              if (cur_r == '0) begin
                root_nxt = node_upd;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = node_upd;
              end
              octl.emit       = 1'b1;
              octl.res.status = pctd_pkg::ST_OK;
              state_nxt       = S_FLUSH;
            end
          end

          pctd_pkg::ACT_LOOKUP: begin
            if (cnt_r != '0) begin
              if (child != '0) begin
                cur_nxt    = child;
                ram_re     = 1'b1;
                use_rd_nxt = 1'b1;
                cnt_nxt    = cnt_r - CW'(1);
                sh_nxt     = sh_r << 1;
              end else begin
                octl.emit       = 1'b1;
                octl.res.status = pctd_pkg::ST_NOT_FOUND;
                state_nxt       = S_FLUSH;
              end
            end else begin
              octl.emit = 1'b1;
              if (node_v.mark) begin
                octl.res.sym    = node_v.sym;
                octl.res.sym_v  = 1'b1;
                octl.res.found  = 1'b1;
                octl.res.status = pctd_pkg::ST_OK;
              end else begin
                octl.res.status = pctd_pkg::ST_NOT_FOUND;
              end
              state_nxt = S_FLUSH;
            end
          end

          pctd_pkg::ACT_DECODE: begin
            if (chk_r && node_v.mark) begin
              if (can_emit) begin
                octl.emit       = 1'b1;
                octl.res.sym    = node_v.sym;
                octl.res.sym_v  = 1'b1;
                octl.res.status = pctd_pkg::ST_OK;
                cur_nxt         = '0;
                chk_nxt         = 1'b0;
              end
            end else if (cnt_r != '0) begin
              if (child != '0) begin
                cur_nxt    = child;
                ram_re     = 1'b1;
                use_rd_nxt = 1'b1;
                chk_nxt    = 1'b1;
                cnt_nxt    = cnt_r - CW'(1);
                sh_nxt     = sh_r << 1;
              end else if (can_emit) begin
                octl.emit       = 1'b1;
                octl.res.status = pctd_pkg::ST_INVALID;
                cur_nxt         = '0;
                chk_nxt         = 1'b0;
                cnt_nxt         = '0;
                state_nxt       = S_END;
              end
            end else begin
              state_nxt = S_END;
            end
          end

          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_ALLOC: begin
        ram_we     = 1'b1;
        ram_waddr  = used_r[IW-1:0];
        ram_wdata  = '0;
        cur_nxt    = used_r[IW-1:0];
        use_rd_nxt = 1'b0;
        used_nxt   = used_r + UW'(1);
        cnt_nxt    = cnt_r - CW'(1);
        sh_nxt     = sh_r << 1;
        state_nxt  = S_WALK;
      end

      S_END: begin
        if (fin_r && cur_r != '0) begin
          if (can_emit) begin
            octl.emit       = 1'b1;
            octl.res.status = pctd_pkg::ST_TRUNC;
            cur_nxt         = '0;
            cursor_nxt      = '0;
            state_nxt       = S_FLUSH;
          end
        end else begin
          cursor_nxt = cur_r;
          state_nxt  = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!osts.pend_v) begin
          state_nxt = S_IDLE;
        end else if (osts.slot) begin
          octl.flush = 1'b1;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      root_r   <= '0;
      used_r   <= UW'(1);
      cursor_r <= '0;
      cur_r    <= '0;
      use_rd_r <= 1'b0;
      chk_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      root_r   <= root_nxt;
      used_r   <= used_nxt;
      cursor_r <= cursor_nxt;
      cur_r    <= cur_nxt;
      use_rd_r <= use_rd_nxt;
      chk_r    <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r    <= act_nxt;
    sh_r     <= sh_nxt;
    cnt_r    <= cnt_nxt;
    sym_in_r <= sym_in_nxt;
    fin_r    <= fin_nxt;
  end

endmodule
